### src/bgc_pkg.sv
`default_nettype none

package bgc_pkg;

    // Width of the tick counters.
    localparam int TIME_WIDTH = 16;
    // Width of the configuration time registers.
    localparam int CFG_TIME_WIDTH = 16;
    // Common width for comparing counters against configured times.
    localparam int CMP_WIDTH = (TIME_WIDTH > CFG_TIME_WIDTH) ? TIME_WIDTH : CFG_TIME_WIDTH;
    // The hold point is a sum of a counter and a period, one bit wider.
    localparam int HOLD_PT_WIDTH = CMP_WIDTH + 1;

    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic [TIME_WIDTH-1:0]      time_t;
    typedef logic [CFG_TIME_WIDTH-1:0]  cfg_time_t;
    typedef logic [CMP_WIDTH-1:0]       cmp_t;
    typedef logic [HOLD_PT_WIDTH-1:0]   hold_pt_t;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    typedef logic [1:0]                 rel_count_t;

    localparam time_t TIME_MAX = '1;

    // Register indexes of the configuration port.
    localparam cfg_index_t REG_ACTIVE_LEVEL      = 3'd0;
    localparam cfg_index_t REG_RELEASE_ON_RISING = 3'd1;
    localparam cfg_index_t REG_HOLD_TIME         = 3'd2;
    localparam cfg_index_t REG_REPEAT_TIME       = 3'd3;
    localparam cfg_index_t REG_SINGLE_TIME       = 3'd4;
    localparam cfg_index_t REG_IDLE_TIME         = 3'd5;

    // Register values after reset.
    localparam logic      RST_ACTIVE_LEVEL      = 1'b0;
    localparam logic      RST_RELEASE_ON_RISING = 1'b1;
    localparam cfg_time_t RST_HOLD_TIME         = 16'd1000;
    localparam cfg_time_t RST_REPEAT_TIME       = 16'd200;
    localparam cfg_time_t RST_SINGLE_TIME       = 16'd300;
    localparam cfg_time_t RST_IDLE_TIME         = 16'd5000;

    // Release counter values.
    localparam rel_count_t REL_NONE   = 2'd0;
    localparam rel_count_t REL_FIRST  = 2'd1;
    localparam rel_count_t REL_SECOND = 2'd2;
    localparam rel_count_t REL_BAD    = 2'd3;

    typedef struct packed {
        logic rising_event;
        logic falling_event;
        logic hold_event;
        logic single_event;
        logic double_event;
        logic idle_event;
    } bgc_result_t;

    // Loads a configured period into a tick counter, saturating at the counter's range.
    function automatic time_t clamp_time(input cfg_time_t value);
        time_t result;
        if (cmp_t'(value) > cmp_t'(TIME_MAX))
        begin
            result = TIME_MAX;
        end
        else
        begin
            result = time_t'(value);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

### src/bgc_in_if.sv
`default_nettype none

interface bgc_in_if;
    logic valid;
    logic ready;
    logic input_level;

    modport source (output valid, output input_level, input ready);
    modport sink (input valid, input input_level, output ready);
endinterface

`default_nettype wire

### src/bgc_out_if.sv
`default_nettype none

interface bgc_out_if;
    import bgc_pkg::*;

    logic        valid;
    logic        ready;
    bgc_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/bgc_cfg_if.sv
`default_nettype none

interface bgc_cfg_if;
    import bgc_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_time_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/button_gesture_classifier.sv
`default_nettype none

// Button gesture classifier. Each transfer on item_in carries one debounced button
// sample, which stands for one timer tick; each one produces exactly one transfer on
// result_out with six event flags: rising and falling edge, hold (and hold repeat),
// single click, double click and idle timeout. The block takes one sample per clock
// cycle while ready is high, and registers its result at the transfer. All state
// for a tick is updated by one short pass of logic at the input transfer, and the
// result lands in a two-entry output buffer, so a sample can still be taken while one
// result waits for the consumer; item_in.ready drops only when both entries are full.
// Configuration writes on cfg are always accepted and apply from the next tick on;
// they should be issued only while no result is outstanding. The press polarity
// (active_level) and the release edge (release_on_rising) are independent settings.
module button_gesture_classifier (
    input  wire      clk,
    input  wire      rst_n,
    bgc_in_if.sink   item_in,
    bgc_out_if.source result_out,
    bgc_cfg_if.sink  cfg
);
    import bgc_pkg::*;

    // Configuration registers.
    logic      active_level_reg;
    logic      release_on_rising_reg;
    cfg_time_t hold_time_reg;
    cfg_time_t repeat_time_reg;
    cfg_time_t single_time_reg;
    cfg_time_t idle_time_reg;

    // Gesture tracking state.
    logic       previous_level_reg, previous_level_next;
    time_t      level_run_reg, level_run_next;
    time_t      press_ticks_reg, press_ticks_next;
    hold_pt_t   hold_point_reg, hold_point_next;
    rel_count_t release_count_reg, release_count_next;
    time_t      click_wait_reg, click_wait_next;
    logic       click_running_reg, click_running_next;
    time_t      idle_ticks_reg, idle_ticks_next;

    // Two-entry output buffer: the head drives result_out, the skid entry catches
    // a result produced while the head is stalled.
    logic        out_valid_reg;
    bgc_result_t out_data_reg;
    logic        skid_valid_reg;
    bgc_result_t skid_data_reg;

    bgc_result_t result;
    logic        in_xfer;
    logic        out_xfer;

    assign cfg.ready          = 1'b1;
    assign item_in.ready      = !skid_valid_reg;
    assign in_xfer            = item_in.valid && item_in.ready;
    assign out_xfer           = out_valid_reg && result_out.ready;
    assign result_out.valid   = out_valid_reg;
    assign result_out.data    = out_data_reg;

    // Configuration write decode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg      <= RST_ACTIVE_LEVEL;
            release_on_rising_reg <= RST_RELEASE_ON_RISING;
            hold_time_reg         <= RST_HOLD_TIME;
            repeat_time_reg       <= RST_REPEAT_TIME;
            single_time_reg       <= RST_SINGLE_TIME;
            idle_time_reg         <= RST_IDLE_TIME;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ACTIVE_LEVEL:      active_level_reg      <= cfg.data[0];
                REG_RELEASE_ON_RISING: release_on_rising_reg <= cfg.data[0];
                REG_HOLD_TIME:         hold_time_reg         <= cfg.data;
                REG_REPEAT_TIME:       repeat_time_reg       <= cfg.data;
                REG_SINGLE_TIME:       single_time_reg       <= cfg.data;
                REG_IDLE_TIME:         idle_time_reg         <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // One tick of the classifier. The steps run in a fixed order within the tick:
    // edge detection, run length, hold check, release handling, click window, idle.
    always_comb
    begin
        logic level;
        logic rising;
        logic falling;
        logic release_edge;
        logic hold_ev;
        logic single_ev;
        logic double_ev;
        logic idle_ev;
        rel_count_t count_inc;

        level   = item_in.input_level;
        rising  = !previous_level_reg && level;
        falling = previous_level_reg && !level;

        hold_ev   = 1'b0;
        single_ev = 1'b0;
        double_ev = 1'b0;
        idle_ev   = 1'b0;
        count_inc = '0;

        previous_level_next = level;
        press_ticks_next    = press_ticks_reg;
        hold_point_next     = hold_point_reg;
        release_count_next  = release_count_reg;
        click_wait_next     = click_wait_reg;
        click_running_next  = click_running_reg;
        idle_ticks_next     = idle_ticks_reg;

        // Ticks since the last level change, saturating.
        if (rising || falling)
        begin
            level_run_next = '0;
        end
        else if (level_run_reg != TIME_MAX)
        begin
            level_run_next = level_run_reg + time_t'(1);
        end
        else
        begin
            level_run_next = level_run_reg;
        end

        // While pressed, report a hold once past the threshold and then again each
        // time the press passes the next repeat point.
        if (level == active_level_reg)
        begin
            press_ticks_next = level_run_next;
            if ((cmp_t'(level_run_next) > cmp_t'(hold_time_reg)) &&
                (hold_point_reg < hold_pt_t'(level_run_next)))
            begin
                hold_point_next    = hold_pt_t'(level_run_next) + hold_pt_t'(repeat_time_reg);
                release_count_next = REL_NONE;
                idle_ticks_next    = clamp_time(idle_time_reg);
                hold_ev            = 1'b1;
            end
        end

        // A release classifies the press that just ended.
        release_edge = release_on_rising_reg ? rising : falling;
        if (release_edge)
        begin
            idle_ticks_next = clamp_time(idle_time_reg);
            count_inc       = release_count_next + rel_count_t'(1);
            if (count_inc == REL_FIRST)
            begin
                release_count_next = count_inc;
                if (cmp_t'(press_ticks_next) <= cmp_t'(single_time_reg))
                begin
                    // Short press: wait for a possible second click.
                    click_wait_next    = clamp_time(single_time_reg);
                    click_running_next = 1'b1;
                end
                else if (cmp_t'(press_ticks_next) <= cmp_t'(hold_time_reg))
                begin
                    // Medium press counts as a single click right away.
                    single_ev          = 1'b1;
                    release_count_next = REL_NONE;
                end
                else
                begin
                    release_count_next = REL_NONE;
                end
            end
            else if (count_inc == REL_SECOND)
            begin
                double_ev          = cmp_t'(press_ticks_next) <= cmp_t'(hold_time_reg);
                click_running_next = 1'b0;
                release_count_next = REL_NONE;
            end
            else
            begin
                release_count_next = REL_NONE;
            end
            hold_point_next = '0;
        end

        // Double-click window: expiry turns the pending click into a single click.
        if (click_running_next)
        begin
            if (click_wait_next == '0)
            begin
                click_running_next = 1'b0;
                single_ev          = 1'b1;
                release_count_next = REL_NONE;
            end
            else
            begin
                click_wait_next = click_wait_next - time_t'(1);
            end
        end

        // Idle timer reloads itself on expiry.
        if (idle_ticks_next == '0)
        begin
            idle_ticks_next = clamp_time(idle_time_reg);
            idle_ev         = 1'b1;
        end
        else
        begin
            idle_ticks_next = idle_ticks_next - time_t'(1);
        end

        result.rising_event  = rising;
        result.falling_event = falling;
        result.hold_event    = hold_ev;
        result.single_event  = single_ev;
        result.double_event  = double_ev;
        result.idle_event    = idle_ev;
    end

    // Gesture state advances only on an input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_level_reg <= !RST_ACTIVE_LEVEL;
            level_run_reg      <= '0;
            press_ticks_reg    <= '0;
            hold_point_reg     <= '0;
            release_count_reg  <= REL_NONE;
            click_wait_reg     <= '0;
            click_running_reg  <= 1'b0;
            idle_ticks_reg     <= clamp_time(RST_IDLE_TIME);
        end
        else if (in_xfer)
        begin
            previous_level_reg <= previous_level_next;
            level_run_reg      <= level_run_next;
            press_ticks_reg    <= press_ticks_next;
            hold_point_reg     <= hold_point_next;
            release_count_reg  <= release_count_next;
            click_wait_reg     <= click_wait_next;
            click_running_reg  <= click_running_next;
            idle_ticks_reg     <= idle_ticks_next;
        end
    end

    // Output buffer control. A new result can only arrive while the skid entry
    // is empty, so a pop from the skid entry never collides with a push.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_xfer)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_xfer;
            end
        end
        else if (in_xfer)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_xfer && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (in_xfer && (out_xfer || !out_valid_reg))
        begin
            out_data_reg <= result;
        end
        if (in_xfer && out_valid_reg && !out_xfer)
        begin
            skid_data_reg <= result;
        end
    end

    // The skid entry is only ever filled behind a waiting head entry.
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the head entry is empty");

    // The release counter wraps before it can reach its unused code.
    a_release_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        release_count_reg != REL_BAD)
        else $error("release counter reached an unused value");

    // A pending first click means the click window is running. A hold may clear
    // the pending click while the window keeps running, so the converse is not true.
    a_click_window_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (release_count_reg == REL_FIRST) |-> click_running_reg)
        else $error("first release pending without a running click window");

    // One tick never reports both a single and a double click.
    a_click_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.single_event && out_data_reg.double_event))
        else $error("single and double click reported in the same tick");

endmodule

`default_nettype wire

### tb/sv/tb_button_gesture_classifier.sv
`timescale 1ns / 100ps

// Testbench for the button gesture classifier.
//
// A driver process offers button samples from a queue of pending levels that the main
// initial block fills phase by phase. A monitor process watches both channels at the
// rising clock edge: every accepted sample is run through a tick-accurate predictor of
// the classifier, and the predicted event flags are queued. Every result transfer is
// compared flag by flag with the oldest queued prediction.
//
// The settings registers are only written while the classifier is drained, between
// phases. The phases cover the reset settings, a short directed walk through every
// gesture, and random gesture streams under several settings, among them the zero
// and the full-range extremes and both inconsistent pairings of press level and
// release edge.
module tb_button_gesture_classifier;
    import bgc_pkg::*;

    // Generous cap on the whole run, in clock cycles.
    localparam int CYCLE_LIMIT = 1000000;
    // Longest run of one level that the random gestures produce.
    localparam int RUN_CAP = 64;
    // Length of the one long receiver stall.
    localparam int HOLD_OFF_CYCLES = 400;
    // Cycles to let pass once everything expected has arrived.
    localparam int SETTLE_CYCLES = 4;

    logic clk;
    logic rst_n;

    bgc_in_if  in_ch();
    bgc_out_if out_ch();
    bgc_cfg_if cfg_ch();

    button_gesture_classifier DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (in_ch),
        .result_out (out_ch),
        .cfg        (cfg_ch)
    );

    // Settings as the predictor sees them. They start at the reset values and follow
    // every write on the settings channel.
    logic      cfg_active_level      = RST_ACTIVE_LEVEL;
    logic      cfg_release_on_rising = RST_RELEASE_ON_RISING;
    cfg_time_t cfg_hold_time         = RST_HOLD_TIME;
    cfg_time_t cfg_repeat_time       = RST_REPEAT_TIME;
    cfg_time_t cfg_single_time       = RST_SINGLE_TIME;
    cfg_time_t cfg_idle_time         = RST_IDLE_TIME;

    // Predictor state, at its reset values. The last level starts out as the
    // inactive level of the reset settings.
    logic       last_level    = !RST_ACTIVE_LEVEL;
    time_t      run_ticks     = '0;
    time_t      pressed_ticks = '0;
    hold_pt_t   hold_point    = '0;
    rel_count_t releases      = REL_NONE;
    time_t      window_ticks  = '0;
    logic       window_open   = 1'b0;
    time_t      idle_count    = clamp_time(RST_IDLE_TIME);

    // Levels still to be offered, and event flags still to be seen.
    logic        pending_levels[$];
    bgc_result_t expected_events[$];
    int          queued_total = 0;

    // Traffic shaping. steady switches off all random idling on both sides, and
    // hold_off_request asks the receiver for its one long stall.
    logic steady           = 1'b0;
    logic hold_off_request = 1'b0;
    logic hold_off_served  = 1'b0;
    int   hold_off_left    = 0;

    // Set at a rising edge when a sample was transferred there; the driver uses it at
    // the following falling edge to move on to the next sample.
    logic in_fire = 1'b0;

    int error_count = 0;
    int cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Advances the predictor by one tick and returns the events of that tick. The order
    // within a tick is edge detection, run count, hold check, release handling, the
    // double click window and last the idle timer.
    function automatic bgc_result_t classify_tick(input logic level);
        bgc_result_t events;
        logic        release_edge;
        events = '0;
        events.rising_event  = (last_level == 1'b0) && (level == 1'b1);
        events.falling_event = (last_level == 1'b1) && (level == 1'b0);
        // The run count restarts on any level change and otherwise saturates.
        if (events.rising_event || events.falling_event)
        begin
            run_ticks = '0;
        end
        else if (run_ticks != TIME_MAX)
        begin
            run_ticks = run_ticks + 1'b1;
        end
        last_level = level;

        // While pressed, a hold fires once the run passes the hold time and again each
        // time it passes the next hold point.
        if (level == cfg_active_level)
        begin
            pressed_ticks = run_ticks;
            if ((pressed_ticks > cfg_hold_time) && (hold_point < hold_pt_t'(pressed_ticks)))
            begin
                hold_point         = hold_pt_t'(pressed_ticks) + hold_pt_t'(cfg_repeat_time);
                releases           = REL_NONE;
                idle_count         = clamp_time(cfg_idle_time);
                events.hold_event  = 1'b1;
            end
        end

        // A release classifies the press that came before it. With inconsistent
        // settings the release edge may start a press, which then sees a press of zero.
        release_edge = cfg_release_on_rising ? events.rising_event : events.falling_event;
        if (release_edge)
        begin
            idle_count = clamp_time(cfg_idle_time);
            releases   = releases + 1'b1;
            if (releases == REL_FIRST)
            begin
                if (pressed_ticks <= cfg_single_time)
                begin
                    window_ticks = clamp_time(cfg_single_time);
                    window_open  = 1'b1;
                end
                else if (pressed_ticks <= cfg_hold_time)
                begin
                    events.single_event = 1'b1;
                    releases            = REL_NONE;
                end
                else
                begin
                    releases = REL_NONE;
                end
            end
            else if (releases == REL_SECOND)
            begin
                if (pressed_ticks <= cfg_hold_time)
                begin
                    events.double_event = 1'b1;
                end
                window_open = 1'b0;
                releases    = REL_NONE;
            end
            else
            begin
                releases = REL_NONE;
            end
            hold_point = '0;
        end

        // The window is checked in the tick it opens, so a window of zero closes at once.
        if (window_open)
        begin
            if (window_ticks == '0)
            begin
                window_open         = 1'b0;
                events.single_event = 1'b1;
                releases            = REL_NONE;
            end
            else
            begin
                window_ticks = window_ticks - 1'b1;
            end
        end

        // The idle timer reloads itself on expiry, so an idle time of zero fires on
        // every tick without activity.
        if (idle_count == '0)
        begin
            idle_count        = clamp_time(cfg_idle_time);
            events.idle_event = 1'b1;
        end
        else
        begin
            idle_count = idle_count - 1'b1;
        end
        return events;
    endfunction

    task automatic check_flag(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %b, actual %b", $time, name, want, got);
            error_count++;
        end
    endtask

    // Monitor: result transfers are checked first, then a sample transfer at the same
    // edge is predicted, so a result can never be matched against its own sample.
    always @(posedge clk)
    begin
        bgc_result_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            in_fire <= rst_n && in_ch.valid && in_ch.ready;
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t ns: result transfer with nothing expected, actual %b",
                             $time, out_ch.data);
                    error_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_flag("rising_event", want.rising_event, out_ch.data.rising_event);
                    check_flag("falling_event", want.falling_event, out_ch.data.falling_event);
                    check_flag("hold_event", want.hold_event, out_ch.data.hold_event);
                    check_flag("single_event", want.single_event, out_ch.data.single_event);
                    check_flag("double_event", want.double_event, out_ch.data.double_event);
                    check_flag("idle_event", want.idle_event, out_ch.data.idle_event);
                end
            end
            if (rst_n && in_ch.valid && in_ch.ready)
            begin
                expected_events.push_back(classify_tick(in_ch.input_level));
            end
        end
    end

    // Driver: once the current sample has been transferred (or none is on offer), it
    // either offers the next pending level or, now and then, idles instead.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (!in_ch.valid || in_fire)
        begin
            if ((pending_levels.size() != 0) && (steady || ($urandom_range(99) >= 6)))
            begin
                in_ch.valid       <= 1'b1;
                in_ch.input_level <= pending_levels.pop_front();
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: ready is mostly high, with random stalls and, once on request, a long
    // stall that lets the output buffer fill and block the input side.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (hold_off_left != 0)
        begin
            out_ch.ready  <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else if (hold_off_request && !hold_off_served)
        begin
            out_ch.ready    <= 1'b0;
            hold_off_left   <= HOLD_OFF_CYCLES;
            hold_off_served <= 1'b1;
        end
        else
        begin
            out_ch.ready <= steady || ($urandom_range(99) >= 6);
        end
    end

    task automatic add_run(input logic level, input int ticks);
        repeat (ticks) pending_levels.push_back(level);
        queued_total += ticks;
    endtask

    // Random run length in [lo, hi], both ends capped so that large settings do not
    // make the run slow.
    function automatic int pick_span(input int lo, input int hi);
        int low_end;
        int high_end;
        low_end  = (lo > RUN_CAP) ? RUN_CAP : lo;
        high_end = (hi > RUN_CAP) ? RUN_CAP : hi;
        if (high_end < low_end)
        begin
            high_end = low_end;
        end
        return int'($urandom_range(high_end, low_end));
    endfunction

    // Waits until every sample has been transferred and every result has been checked,
    // then lets the block settle.
    task automatic wait_for_drain();
        while ((pending_levels.size() != 0) || in_ch.valid || (expected_events.size() != 0))
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One transfer on the settings channel; the predictor takes the new value at the
    // edge where the write is accepted.
    task automatic write_reg(input cfg_index_t idx, input cfg_time_t value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        case (idx)
            REG_ACTIVE_LEVEL:      cfg_active_level      = value[0];
            REG_RELEASE_ON_RISING: cfg_release_on_rising = value[0];
            REG_HOLD_TIME:         cfg_hold_time         = value;
            REG_REPEAT_TIME:       cfg_repeat_time       = value;
            REG_SINGLE_TIME:       cfg_single_time       = value;
            REG_IDLE_TIME:         cfg_idle_time         = value;
            default:               ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Drains the block, then writes all six registers. Random idling is switched back
    // on, since steady only ever covers one phase.
    task automatic program_settings(input logic active, input logic on_rising,
                                    input cfg_time_t hold, input cfg_time_t rep,
                                    input cfg_time_t single, input cfg_time_t idle);
        wait_for_drain();
        steady = 1'b0;
        write_reg(REG_ACTIVE_LEVEL, cfg_time_t'(active));
        write_reg(REG_RELEASE_ON_RISING, cfg_time_t'(on_rising));
        write_reg(REG_HOLD_TIME, hold);
        write_reg(REG_REPEAT_TIME, rep);
        write_reg(REG_SINGLE_TIME, single);
        write_reg(REG_IDLE_TIME, idle);
        @(posedge clk);
    endtask

    // Random gesture stream under the current settings: mostly well-formed clicks,
    // double clicks, medium and long presses and idle gaps, with some level noise.
    task automatic run_random_phase(input int budget);
        int   first;
        int   single;
        int   hold;
        logic press;
        first  = queued_total;
        single = int'(cfg_single_time);
        hold   = int'(cfg_hold_time);
        press  = cfg_active_level;
        while (queued_total - first < budget)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    // Short press, then a gap long enough for the window to run out, unless RUN_CAP cuts it short.
                    add_run(press, pick_span(1, single + 1));
                    add_run(!press, pick_span(single + 2, single + 6));
                end
                2, 3:
                begin
                    // Two short presses with a short gap between them.
                    add_run(press, pick_span(1, single / 2 + 1));
                    add_run(!press, pick_span(1, single / 2 + 1));
                    add_run(press, pick_span(1, single / 2 + 1));
                    add_run(!press, pick_span(1, single + 4));
                end
                4:
                begin
                    add_run(press, pick_span(single + 2, hold + 1));
                    add_run(!press, pick_span(1, single + 4));
                end
                5, 6:
                begin
                    // Long press with a few hold repeats.
                    add_run(press, pick_span(hold + 2, hold + 3 * int'(cfg_repeat_time) + 5));
                    add_run(!press, pick_span(1, 4));
                end
                7:
                begin
                    add_run(!press, pick_span(int'(cfg_idle_time),
                                              int'(cfg_idle_time) * 3 / 2 + 2));
                end
                default:
                begin
                    repeat ($urandom_range(8, 1))
                    begin
                        add_run(logic'($urandom_range(1)), pick_span(1, 3));
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.input_level = 1'b0;
        out_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_ACTIVE_LEVEL;
        cfg_ch.data       = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: the level after reset counts as released, so a first high
        // sample makes no edge. The press that follows opens a long window, which the
        // next settings do not restart.
        add_run(1'b1, 1);
        add_run(1'b0, 1);
        add_run(1'b1, 1);

        // Directed walk with tiny times: idle, single click on window expiry, double
        // click, medium press, and a long press with a hold.
        program_settings(1'b1, 1'b0, 16'd4, 16'd2, 16'd2, 16'd3);
        add_run(1'b0, 3);
        add_run(1'b1, 1);
        add_run(1'b0, 4);
        add_run(1'b1, 1);
        add_run(1'b0, 1);
        add_run(1'b1, 1);
        add_run(1'b0, 3);
        add_run(1'b1, 4);
        add_run(1'b0, 2);
        add_run(1'b1, 8);
        add_run(1'b0, 2);

        // Random phases. The second one carries the long receiver stall and the third
        // one runs without any idling.
        program_settings(1'b1, 1'b0, 16'd8, 16'd3, 16'd3, 16'd20);
        run_random_phase(180);

        program_settings(1'b0, 1'b1, 16'd12, 16'd0, 16'd5, 16'd30);
        run_random_phase(180);
        hold_off_request = 1'b1;

        // Press and release on the same edge.
        program_settings(1'b1, 1'b1, 16'd6, 16'd2, 16'd4, 16'd1);
        steady = 1'b1;
        run_random_phase(180);

        // All periods zero: every started timer expires in the tick it starts.
        program_settings(1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random_phase(180);

        program_settings(logic'($urandom_range(1)), logic'($urandom_range(1)),
                         cfg_time_t'($urandom_range(65535)),
                         cfg_time_t'($urandom_range(65535)),
                         cfg_time_t'($urandom_range(65535)),
                         cfg_time_t'($urandom_range(65535)));
        run_random_phase(180);

        program_settings(logic'($urandom_range(1)), logic'($urandom_range(1)),
                         cfg_time_t'($urandom_range(15)), cfg_time_t'($urandom_range(15)),
                         cfg_time_t'($urandom_range(15)), cfg_time_t'($urandom_range(15)));
        run_random_phase(180);

        // Upper extremes of all time registers.
        program_settings(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random_phase(60);

        wait_for_drain();
        repeat (8) @(posedge clk);
        if (expected_events.size() != 0)
        begin
            $display("%0t ns: %0d expected results never arrived", $time,
                     expected_events.size());
        end
        if ((error_count == 0) && (expected_events.size() == 0))
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
